/* rtl/smf_pkg.sv */
// shared constants and types for the substring match finder
package smf_pkg;

   localparam int PATTERN_MAX   = 16;
   localparam int POSITION_BITS = 24;
   localparam int BYTE_BITS     = 8;
   localparam int START_BITS    = 24;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 2;
   localparam int LEN_BITS      = 5;
   localparam int WIN_IDX_BITS  = $clog2(PATTERN_MAX);
   localparam int HALF_BYTES    = CSR_DATA_BITS / BYTE_BITS;

   localparam logic [LEN_BITS-1:0] PAT_MAX_LEN = LEN_BITS'(PATTERN_MAX);

   // configuration register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LOW  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_HIGH = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_PATTERN_LEN  = CSR_IDX_BITS'(2);

   typedef logic [BYTE_BITS-1:0] byte_type;

   typedef struct packed {
      logic                  match_found;
      logic [START_BITS-1:0] match_start;
      logic                  text_done;
   } rsp_type;

endpackage

/* rtl/substring_match_finder.sv */
// streaming leftmost non-overlapping exact substring finder
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------------
//  req     | in        | req_valid/req_stall | req_text_byte, req_text_last
//  rsp     | out       | rsp_valid/rsp_stall | rsp_match_found, rsp_match_start, rsp_text_done
//  csr     | in        | csr_write_en        | csr_index, csr_data
//
// one text byte is taken every cycle while req_stall is low; its result (if any) is
// registered in the result register, or in the skid entry while that one still waits
// the 16-byte window compare is one level of byte comparators and a select by length
// a two-entry output stage (result register plus skid) lets bytes keep flowing
// while a result waits; req_stall rises only once both entries are full
// reset clears the pattern registers, the window, the position count and the holdoff
module substring_match_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [smf_pkg::BYTE_BITS-1:0]     req_text_byte,
   input  logic                              req_text_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_match_found,
   output logic [smf_pkg::START_BITS-1:0]    rsp_match_start,
   output logic                              rsp_text_done,
   input  logic                              csr_write_en,
   input  logic [smf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [smf_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import smf_pkg::*;

   logic [CSR_DATA_BITS-1:0] pat_low_ff;
   logic [CSR_DATA_BITS-1:0] pat_high_ff;
   logic [LEN_BITS-1:0]      pat_len_ff;

   byte_type                 window_ff [PATTERN_MAX];
   byte_type                 window_in [PATTERN_MAX];
   logic [POSITION_BITS-1:0] bytes_seen_ff;
   logic [POSITION_BITS-1:0] bytes_seen_in;
   logic [LEN_BITS-1:0]      holdoff_ff;
   logic [LEN_BITS-1:0]      holdoff_in;

   rsp_type                  main_ff;
   rsp_type                  skid_ff;
   logic                     main_valid_ff;
   logic                     skid_valid_ff;

   byte_type                 pat_byte [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]   len_eq;
   logic [LEN_BITS-1:0]      len_act;
   logic [LEN_BITS-1:0]      len_m1;
   logic                     long_enough;
   logic                     hit;
   logic                     req_accept;
   logic                     rsp_take;
   logic                     produce;
   rsp_type                  new_rsp;

   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign req_stall  = skid_valid_ff;
   assign rsp_valid  = main_valid_ff;

   assign rsp_match_found = main_ff.match_found;
   assign rsp_match_start = main_ff.match_start;
   assign rsp_text_done   = main_ff.text_done;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         pat_len_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            CSR_PATTERN_LEN:  pat_len_ff  <= csr_data[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (i < HALF_BYTES) begin
            pat_byte[i] = pat_low_ff[(i % HALF_BYTES)*BYTE_BITS +: BYTE_BITS];
         end else begin
            pat_byte[i] = pat_high_ff[(i % HALF_BYTES)*BYTE_BITS +: BYTE_BITS];
         end
      end
   end

   // window after the new byte goes in, entry 0 the newest
   always_comb begin
      window_in[0] = req_text_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         window_in[k] = window_ff[k-1];
      end
   end

   // one equality term per possible length, all on fixed window taps
   always_comb begin
      logic eq;
      for (int l = 1; l <= PATTERN_MAX; l++) begin
         eq = 1'b1;
         for (int i = 0; i < l; i++) begin
            eq = eq && (pat_byte[i] == window_in[l-1-i]);
         end
         len_eq[l-1] = eq;
      end
   end

   assign len_act     = (pat_len_ff > PAT_MAX_LEN) ? PAT_MAX_LEN : pat_len_ff;
   assign len_m1      = len_act - LEN_BITS'(1);
   assign long_enough = bytes_seen_ff >= POSITION_BITS'(len_m1);
   assign hit = (holdoff_ff == '0) && (len_act != '0) && long_enough
                && len_eq[len_m1[WIN_IDX_BITS-1:0]];

   always_comb begin
      new_rsp.match_found = hit;
      new_rsp.match_start = hit ? START_BITS'(bytes_seen_ff - POSITION_BITS'(len_m1))
                                : '0;
      new_rsp.text_done   = req_text_last;
   end

   assign produce = req_accept && (hit || req_text_last);

   always_comb begin
      if (hit) begin
         holdoff_in = len_m1;
      end else if (holdoff_ff != '0) begin
         holdoff_in = holdoff_ff - LEN_BITS'(1);
      end else begin
         holdoff_in = holdoff_ff;
      end
      bytes_seen_in = (bytes_seen_ff != '1) ? bytes_seen_ff + POSITION_BITS'(1)
                                            : bytes_seen_ff;
   end

   // text state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PATTERN_MAX; k++) window_ff[k] <= '0;
         bytes_seen_ff <= '0;
         holdoff_ff    <= '0;
      end else if (req_accept) begin
         if (req_text_last) begin
            for (int k = 0; k < PATTERN_MAX; k++) window_ff[k] <= '0;
            bytes_seen_ff <= '0;
            holdoff_ff    <= '0;
         end else begin
            window_ff     <= window_in;
            bytes_seen_ff <= bytes_seen_in;
            holdoff_ff    <= holdoff_in;
         end
      end
   end

   // output stage: result register plus one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            main_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (produce) begin
         if (main_valid_ff && !rsp_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) main_ff <= skid_ff;
      end else if (produce) begin
         if (main_valid_ff && !rsp_take) begin
            skid_ff <= new_rsp;
         end else begin
            main_ff <= new_rsp;
         end
      end
   end

   // checks
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_match_found || rsp_text_done))
      else $error("result shown with neither a match nor end of text");

   a_holdoff_bound: assert property (@(posedge clock) disable iff (reset)
      holdoff_ff < PAT_MAX_LEN)
      else $error("overlap holdoff beyond pattern length");

   a_text_cleared: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_text_last |=> (bytes_seen_ff == '0) && (holdoff_ff == '0))
      else $error("text state not cleared after end of text");

endmodule

/* tb/substring_match_finder_checker.sv */
// checker for the substring match finder: predicts each report and compares it as it leaves
module substring_match_finder_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  smf_pkg::byte_type                 req_text_byte,
   input  logic                              req_text_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_match_found,
   input  logic [smf_pkg::START_BITS-1:0]    rsp_match_start,
   input  logic                              rsp_text_done,
   input  logic                              csr_write_en,
   input  logic [smf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [smf_pkg::CSR_DATA_BITS-1:0] csr_data,
   output int                                mismatch_count,
   output int                                reports_outstanding,
   output int                                reports_checked,
   output int                                matches_checked,
   output int                                texts_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import smf_pkg::*;

   localparam int MISMATCH_PRINT_LIMIT = 10;
   localparam logic [POSITION_BITS-1:0] POSITION_LIMIT = '1;

   logic [CSR_DATA_BITS-1:0] pattern_low;
   logic [CSR_DATA_BITS-1:0] pattern_high;
   logic [LEN_BITS-1:0]      pattern_len;
   byte_type                 window [PATTERN_MAX];
   logic [POSITION_BITS-1:0] text_position;
   logic [LEN_BITS-1:0]      holdoff;
   rsp_type                  expected_reports [$];
   int                       mismatches = 0;
   int                       checked = 0;
   int                       match_total = 0;
   int                       texts = 0;

   function automatic void clear_text();
      foreach (window[i]) window[i] = '0;
      text_position = '0;
      holdoff = '0;
   endfunction

   // slides the window by one byte and queues the report it causes, if any
   function automatic void scan_text_byte(byte_type text_byte, logic text_last);
      logic [2*CSR_DATA_BITS-1:0] pattern;
      logic [LEN_BITS-1:0]        len;
      logic                       hit;
      rsp_type                    report;
      pattern = {pattern_high, pattern_low};
      len = (pattern_len > PAT_MAX_LEN) ? PAT_MAX_LEN : pattern_len;
      hit = 1'b0;
      report = '0;
      for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = text_byte;
      if (holdoff != 0) begin
         holdoff = holdoff - 1'b1;
      end else if (len != 0 && 32'(text_position) + 32'd1 >= 32'(len)) begin
         hit = 1'b1;
         for (int i = 0; i < int'(len); i++) begin
            if (pattern[i*BYTE_BITS +: BYTE_BITS] != window[int'(len) - 1 - i]) hit = 1'b0;
         end
         if (hit) begin
            report.match_start = START_BITS'(text_position - POSITION_BITS'(len) + 1'b1);
            // no further occurrence may start inside this one
            holdoff = len - 1'b1;
         end
      end
      if (text_position != POSITION_LIMIT) text_position = text_position + 1'b1;
      if (hit || text_last) begin
         report.match_found = hit;
         report.text_done = text_last;
         expected_reports.push_back(report);
      end
      if (text_last) clear_text();
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         pattern_low = '0;
         pattern_high = '0;
         pattern_len = '0;
         clear_text();
         expected_reports.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_PATTERN_LOW:  pattern_low = csr_data;
               CSR_PATTERN_HIGH: pattern_high = csr_data;
               CSR_PATTERN_LEN:  pattern_len = csr_data[LEN_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) scan_text_byte(req_text_byte, req_text_last);
         if (rsp_valid && !rsp_stall) begin
            seen.match_found = rsp_match_found;
            seen.match_start = rsp_match_start;
            seen.text_done = rsp_text_done;
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= MISMATCH_PRINT_LIMIT)
                  $display("unexpected report: found %0b start %0d done %0b",
                           seen.match_found, seen.match_start, seen.text_done);
            end else begin
               want = expected_reports.pop_front();
               checked++;
               if (seen.match_found !== want.match_found
                   || seen.match_start !== want.match_start
                   || seen.text_done !== want.text_done) begin
                  mismatches++;
                  if (mismatches <= MISMATCH_PRINT_LIMIT)
                     $display("report %0d: expected found %0b start %0d done %0b, got %0b %0d %0b",
                              checked, want.match_found, want.match_start, want.text_done,
                              seen.match_found, seen.match_start, seen.text_done);
               end
               if (want.match_found) match_total++;
               if (want.text_done) texts++;
            end
         end
      end
      mismatch_count <= mismatches;
      reports_outstanding <= expected_reports.size();
      reports_checked <= checked;
      matches_checked <= match_total;
      texts_checked <= texts;
   end

endmodule

/* tb/substring_match_finder_tb.sv */
// top of the substring match finder testbench: stimulus, idling and verdict
module substring_match_finder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smf_pkg::*;

   localparam int RANDOM_ITEMS  = 830;
   localparam int IDLE_LIMIT    = 1000;
   localparam int HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_MAX      = 8;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = CSR_IDX_BITS'(3);

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   byte_type                 req_text_byte = '0;
   logic                     req_text_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_match_found;
   logic [START_BITS-1:0]    rsp_match_start;
   logic                     rsp_text_done;
   logic                     csr_write_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_PATTERN_LOW;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   int mismatch_count;
   int reports_outstanding;
   int reports_checked;
   int matches_checked;
   int texts_checked;

   int unsigned send_gap_max = 3;
   int unsigned stall_max = 3;
   bit          hold_request = 1'b0;
   int          items_sent = 0;
   int          settings_used = 0;
   int unsigned alphabet_base = 1;
   int unsigned alphabet_span = 0;

   substring_match_finder dut (.*);

   substring_match_finder_checker report_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // draws from the current alphabet; a span of zero means any non-zero byte
   function automatic byte_type draw_text_byte();
      if (alphabet_span == 0) return byte_type'($urandom_range(255, 1));
      return byte_type'(alphabet_base + $urandom_range(alphabet_span - 1, 0));
   endfunction

   task automatic send_text_byte(input byte_type text_byte, input logic text_last);
      int unsigned gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= text_byte;
      req_text_last <= text_last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic program_pattern(input logic [2*CSR_DATA_BITS-1:0] pattern_bits,
                                  input logic [CSR_DATA_BITS-1:0] len_word,
                                  input bit poke_unused);
      csr_write_en <= 1'b1;
      csr_index <= CSR_PATTERN_LOW;
      csr_data <= pattern_bits[CSR_DATA_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_PATTERN_HIGH;
      csr_data <= pattern_bits[2*CSR_DATA_BITS-1:CSR_DATA_BITS];
      @(posedge clock);
      csr_index <= CSR_PATTERN_LEN;
      csr_data <= len_word;
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_UNUSED;
         csr_data <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // every expected report in, then a settling wait for bytes that report nothing
   task automatic wait_until_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (reports_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result receiver: a random stall before each transaction, one long hold on request
   initial begin
      int unsigned wait_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            wait_cycles = HOLD_CYCLES;
         end else begin
            wait_cycles = $urandom_range(stall_max, 0);
         end
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_write_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("substring_match_finder_tb failed");
      $finish;
   end

   initial begin
      logic [2*CSR_DATA_BITS-1:0] pattern_bits;
      byte_type                   text_q [$];
      byte_type                   text_byte;
      int unsigned                pattern_len;
      int unsigned                active_len;
      int unsigned                text_len;
      int unsigned                texts;
      bit                         end_mid_text;
      int                         random_start;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty pattern straight out of reset: only the end of text reports
      send_text_byte(8'h01, 1'b1);
      wait_until_idle();

      // length above the maximum, all-ones pattern: the match lands on the last byte
      program_pattern('1, CSR_DATA_BITS'(31), 1'b1);
      for (int i = 0; i < PATTERN_MAX; i++) send_text_byte(8'hFF, i == PATTERN_MAX - 1);
      wait_until_idle();

      // "aba" on "abab", then mid-text the length grows over a zero pattern byte
      program_pattern(128'h0061_6261, CSR_DATA_BITS'(3), 1'b0);
      send_text_byte(8'h61, 1'b0);
      send_text_byte(8'h62, 1'b0);
      send_text_byte(8'h61, 1'b0);
      send_text_byte(8'h62, 1'b0);
      wait_until_idle();
      program_pattern(128'h0061_6261, CSR_DATA_BITS'(4), 1'b0);
      send_text_byte(8'h61, 1'b0);
      send_text_byte(8'h62, 1'b0);
      send_text_byte(8'h61, 1'b1);
      wait_until_idle();

      random_start = items_sent;
      for (int phase = 0; items_sent - random_start < RANDOM_ITEMS; phase++) begin
         if ($urandom_range(2, 0) == 0) begin
            send_gap_max = 0;
            stall_max = 0;
         end else if ($urandom_range(1, 0) == 0) begin
            send_gap_max = IDLE_MAX;
            stall_max = IDLE_MAX;
         end else begin
            send_gap_max = $urandom_range(IDLE_MAX, 0);
            stall_max = $urandom_range(IDLE_MAX, 0);
         end
         case ($urandom_range(9, 0))
            0:       pattern_len = 0;
            1:       pattern_len = PATTERN_MAX;
            2:       pattern_len = $urandom_range(31, PATTERN_MAX + 1);
            default: pattern_len = $urandom_range(6, 1);
         endcase
         if ($urandom_range(3, 0) == 0) begin
            alphabet_span = 0;
         end else begin
            alphabet_span = $urandom_range(3, 1);
            alphabet_base = $urandom_range(256 - alphabet_span, 1);
         end
         // one byte repeated while the receiver holds off: the block must back up
         if (phase == 1) begin
            pattern_len = 1;
            alphabet_span = 1;
            send_gap_max = 0;
            stall_max = 0;
            hold_request = 1'b1;
         end
         for (int i = 0; i < PATTERN_MAX; i++) pattern_bits[i*BYTE_BITS +: BYTE_BITS] = draw_text_byte();
         if (phase != 1 && $urandom_range(9, 0) == 0)
            pattern_bits[$urandom_range(PATTERN_MAX - 1, 0)*BYTE_BITS +: BYTE_BITS] = '0;
         program_pattern(pattern_bits, CSR_DATA_BITS'(pattern_len), $urandom_range(7, 0) == 0);
         active_len = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;

         texts = $urandom_range(4, 1);
         for (int t = 0; t < int'(texts); t++) begin
            text_len = $urandom_range(24, 1);
            if ($urandom_range(3, 0) == 0) text_len += 2 * active_len;
            text_q.delete();
            while (text_q.size() < text_len) begin
               if (active_len != 0 && $urandom_range(2, 0) == 0) begin
                  // planted copy of the pattern, now and then with a byte or more spoilt; zero bytes are always redrawn
                  for (int i = 0; i < int'(active_len); i++) begin
                     text_byte = pattern_bits[i*BYTE_BITS +: BYTE_BITS];
                     if (text_byte == 0 || $urandom_range(15, 0) == 0) text_byte = draw_text_byte();
                     text_q.push_back(text_byte);
                  end
               end else begin
                  text_q.push_back(draw_text_byte());
               end
            end
            // leaving the last text open carries it into the next pattern setting
            end_mid_text = (t == int'(texts) - 1) && ($urandom_range(3, 0) == 0);
            foreach (text_q[i])
               send_text_byte(text_q[i], i == text_q.size() - 1 && !end_mid_text);
         end
         wait_until_idle();
      end

      $display("%0d text bytes under %0d pattern settings, one long receiver hold",
               items_sent, settings_used);
      $display("%0d reports checked: %0d matches, %0d texts closed",
               reports_checked, matches_checked, texts_checked);
      if (reports_outstanding != 0)
         $display("%0d expected reports never arrived", reports_outstanding);
      if (mismatch_count == 0 && reports_outstanding == 0) begin
         $display("substring_match_finder_tb passed");
      end else begin
         $display("substring_match_finder_tb failed");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/smf_pkg.sv
rtl/substring_match_finder.sv
tb/substring_match_finder_checker.sv
tb/substring_match_finder_tb.sv
